FILE: sv/ntts_pkg.sv
// Package for the note tone timer sequencer: status codes, opcodes, tables and shared types.
package ntts_pkg;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_TONE     = 3'd1,
    ST_REST     = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_FINISHED = 3'd4
  } status_e;

  typedef enum logic {
    OP_PLAY = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  localparam logic [7:0] NOTE_REST = 8'hFF;
  localparam logic [3:0] NOTE_MAX  = 4'hB;
  localparam logic [3:0] OCT_MIN   = 4'd4;
  localparam logic [3:0] OCT_MAX   = 4'd8;
  localparam int unsigned NUM_PS   = 5;

  localparam logic [0:0] REG_ENABLED = 1'b0;

  // Result of the divisor search for one note code.
  typedef struct packed {
    logic       ok;
    logic [7:0] compare;
    logic [2:0] sel;
  } tone_t;

  // Configuration state handed from the register port to the sequencer.
  typedef struct packed {
    logic enabled;
    logic stop;
  } cfg_t;

  function automatic logic [15:0] base_lookup(input logic [3:0] note);
    logic [15:0] v;
    case (note)
      4'd0:    v = 16'd61155;
      4'd1:    v = 16'd57724;
      4'd2:    v = 16'd54485;
      4'd3:    v = 16'd51425;
      4'd4:    v = 16'd48539;
      4'd5:    v = 16'd45815;
      4'd6:    v = 16'd43244;
      4'd7:    v = 16'd40816;
      4'd8:    v = 16'd38526;
      4'd9:    v = 16'd36364;
      4'd10:   v = 16'd34323;
      4'd11:   v = 16'd32397;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // log2 of 2 * prescaler for prescalers 1, 8, 64, 256, 1024
  function automatic logic [3:0] ps_shift(input logic [2:0] k);
    logic [3:0] s;
    case (k)
      3'd0:    s = 4'd1;
      3'd1:    s = 4'd4;
      3'd2:    s = 4'd7;
      3'd3:    s = 4'd9;
      default: s = 4'd11;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/ntts_tone.sv
// Divisor lookup, octave shift and prescaler search for one note code.
module ntts_tone import ntts_pkg::*; (
  input  logic [7:0] note_code_i,
  output tone_t      tone_o
);

  logic [3:0]  note;
  logic [3:0]  oct;
  logic        code_ok;
  logic [2:0]  oct_shift;
  logic [15:0] base;

  assign note      = note_code_i[3:0];
  assign oct       = note_code_i[7:4];
  assign code_ok   = (note <= NOTE_MAX) && (oct >= OCT_MIN) && (oct <= OCT_MAX);
  assign oct_shift = 3'(oct - OCT_MIN);
  assign base      = base_lookup(note) >> oct_shift;

  // first prescaler whose quotient lands in 2..256 wins
  always_comb begin
    logic        found;
    logic [15:0] q;
    logic [8:0]  cnt;
    found  = 1'b0;
    q      = '0;
    cnt    = '0;
    tone_o = '0;
    for (int k = 0; k < NUM_PS; k++) begin
      q = base >> ps_shift(3'(k));
      if (!found && (q >= 16'd2) && (q <= 16'd256)) begin
        found          = 1'b1;
        cnt            = q[8:0] - 9'd1;
        tone_o.compare = cnt[7:0];
        tone_o.sel     = 3'(k + 1);
      end
    end
    tone_o.ok = found && code_ok;
    if (!tone_o.ok) begin
      tone_o.compare = '0;
      tone_o.sel     = '0;
    end
  end

endmodule

FILE: sv/ntts_apb.sv
// APB register port holding the enable bit.
module ntts_apb import ntts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic enabled_q, enabled_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ENABLED);

  always_comb begin
    enabled_d = enabled_q;
    if (wr_en) begin
      enabled_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else begin
      enabled_q <= enabled_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENABLED) begin
      prdata = {31'd0, enabled_q};
    end
  end

  assign cfg_o.enabled = enabled_q;
  assign cfg_o.stop    = wr_en && !pwdata[0];

endmodule

FILE: sv/note_tone_timer_sequencer_unit.sv
// Top level of the note tone timer sequencer: input register, sequencing state, result register.
// Path: an accepted item waits in the input register, then moves to the result register
//   once that is free or draining; out_valid_o is the result register's valid bit.
// Throughput: one item per cycle unless the output stalls; the note search and tick count settle
//   between the two registers, and the result register frees as soon as its transfer completes.
// Reset (rst_ni low, asynchronous): both pipeline registers empty, enabled 0, not playing,
//   tick count 0. No clearing pass.
module note_tone_timer_sequencer_unit import ntts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // play requests and ticks
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  note_code_i,
  input  logic [15:0] duration_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        timer_write_o,
  output logic [7:0]  compare_value_o,
  output logic [2:0]  clock_select_o,
  output logic        counter_clear_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  tone_t tone;

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic        s1_op_q;
  logic [7:0]  s1_code_q;
  logic [15:0] s1_dur_q;

  // sequencing state
  logic        playing_q, playing_d;
  logic [15:0] remain_q, remain_d;

  // result register
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic        twr_q, twr_d;
  logic [7:0]  cmp_q, cmp_d;
  logic [2:0]  sel_q, sel_d;
  logic        clr_q, clr_d;

  logic in_xfer;
  logic adv;
  logic [15:0] remain_dec;

  ntts_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ntts_tone u_tone (
    .note_code_i (s1_code_q),
    .tone_o      (tone)
  );

  // Item leaves the input register when the result register is free or draining.
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign remain_dec = remain_q - 16'd1;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    playing_d   = playing_q;
    remain_d    = remain_q;
    status_d    = status_q;
    twr_d       = twr_q;
    cmp_d       = cmp_q;
    sel_d       = sel_q;
    clr_d       = clr_q;

    if (adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (adv) begin
      out_valid_d = 1'b1;
      status_d    = ST_NONE;
      twr_d       = 1'b0;
      cmp_d       = '0;
      sel_d       = '0;
      clr_d       = 1'b0;
      if (s1_op_q == OP_TICK) begin
        // ticks only count while enabled and playing; finish stops the timer
        if (cfg.enabled && playing_q) begin
          remain_d = remain_dec;
          if (remain_dec == 16'd0) begin
            playing_d = 1'b0;
            status_d  = ST_FINISHED;
            twr_d     = 1'b1;
          end
        end
      end else if (!cfg.enabled || playing_q) begin
        status_d = ST_REFUSED;
      end else if (s1_code_q == NOTE_REST) begin
        playing_d = 1'b1;
        remain_d  = s1_dur_q;
        status_d  = ST_REST;
      end else if (!tone.ok) begin
        status_d = ST_REFUSED;
      end else begin
        playing_d = 1'b1;
        remain_d  = s1_dur_q;
        status_d  = ST_TONE;
        twr_d     = 1'b1;
        cmp_d     = tone.compare;
        sel_d     = tone.sel;
        clr_d     = 1'b1;
      end
    end

    // disabling drops a note in progress silently
    if (cfg.stop) begin
      playing_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      playing_q   <= 1'b0;
      remain_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      playing_q   <= playing_d;
      remain_q    <= remain_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q   <= opcode_i;
      s1_code_q <= note_code_i;
      s1_dur_q  <= duration_i;
    end
    status_q <= status_d;
    twr_q    <= twr_d;
    cmp_q    <= cmp_d;
    sel_q    <= sel_d;
    clr_q    <= clr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign timer_write_o   = twr_q;
  assign compare_value_o = cmp_q;
  assign clock_select_o  = sel_q;
  assign counter_clear_o = clr_q;

endmodule

FILE: bench/note_tone_timer_sequencer_unit_tb.sv
// Self-checking testbench for the note tone timer sequencer: random traffic scored against a predictor.
`timescale 1ns / 100ps

module note_tone_timer_sequencer_unit_tb;
  import ntts_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off plus stall/gap tails.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLDOFF_AT     = 400;   // results seen before the long stall
  localparam int unsigned HOLDOFF_LEN    = 300;

  // Divisor per note C..H at octave 4, and the prescaler ladder of the timer.
  localparam int unsigned NOTE_DIVISOR [0:11] = '{
    61155, 57724, 54485, 51425, 48539, 45815,
    43244, 40816, 38526, 36364, 34323, 32397
  };
  localparam int unsigned PRESCALE [0:4] = '{1, 8, 64, 256, 1024};

  // One input transfer: a play request or a duration tick.
  typedef struct packed {
    opcode_e     op;
    logic [7:0]  code;
    logic [15:0] dur;
  } note_req_t;

  // One result transfer: status plus the timer programming it carries.
  typedef struct packed {
    status_e    status;
    logic       wr;
    logic [7:0] cmp;
    logic [2:0] sel;
    logic       clr;
  } timer_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [7:0]  note_code_i = 8'd0;
  logic [15:0] duration_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        timer_write_o;
  logic [7:0]  compare_value_o;
  logic [2:0]  clock_select_o;
  logic        counter_clear_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  note_tone_timer_sequencer_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .note_code_i,
    .duration_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .timer_write_o,
    .compare_value_o,
    .clock_select_o,
    .counter_clear_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // Predicted sequencer state, kept in step with accepted transfers and
  // register writes.
  logic        tone_enabled = 1'b0;
  logic        tone_playing = 1'b0;
  logic [15:0] ticks_left   = 16'd0;

  note_req_t  note_reqs[$];          // stimulus waiting to be offered
  timer_cmd_t timer_cmds_due[$];     // predicted results, oldest first

  int unsigned n_fail = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;

  // Sender burst/gap shaping
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // Receiver stall pattern and the one long hold-off
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Next result for one accepted item; updates the predicted state.
  function automatic timer_cmd_t sequence_step(input logic op, input logic [7:0] code,
                                               input logic [15:0] dur);
    timer_cmd_t  r;
    int unsigned base;
    int unsigned q;
    logic [3:0]  note;
    logic [3:0]  oct;
    r = '{ST_NONE, 1'b0, 8'd0, 3'd0, 1'b0};
    if (op == OP_TICK) begin
      // ticks only count while a note or rest is running
      if (tone_enabled && tone_playing) begin
        ticks_left = ticks_left - 16'd1;
        if (ticks_left == 16'd0) begin
          tone_playing = 1'b0;
          r.status = ST_FINISHED;
          r.wr = 1'b1;       // stop: compare 0, clock select 0
        end
      end
    end else if (!tone_enabled || tone_playing) begin
      r.status = ST_REFUSED;
    end else if (code == NOTE_REST) begin
      tone_playing = 1'b1;
      ticks_left = dur;
      r.status = ST_REST;
    end else begin
      note = code[3:0];
      oct = code[7:4];
      if (note <= NOTE_MAX && oct >= OCT_MIN && oct <= OCT_MAX) begin
        base = NOTE_DIVISOR[note] >> (oct - OCT_MIN);
        // first prescaler whose compare value lands in 1..255 wins
        for (int k = 0; k < 5; k++) begin
          q = base / (2 * PRESCALE[k]);
          if (r.sel == 3'd0 && q >= 2 && q <= 256) begin
            r.cmp = 8'(q - 1);
            r.sel = 3'(k + 1);
          end
        end
      end
      if (r.sel == 3'd0) begin
        r.status = ST_REFUSED;
      end else begin
        tone_playing = 1'b1;
        ticks_left = dur;
        r.status = ST_TONE;
        r.wr = 1'b1;
        r.clr = 1'b1;
      end
    end
    return r;
  endfunction

  // Any code that names a real tone: octave 4..8, note C..H.
  function automatic logic [7:0] tone_code();
    return {4'($urandom_range(OCT_MIN, OCT_MAX)), 4'($urandom_range(0, NOTE_MAX))};
  endfunction

  // A code with a bad note or a bad octave, never the rest code.
  function automatic logic [7:0] bad_code();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = {4'($urandom_range(0, 15)), 4'($urandom_range(NOTE_MAX + 1, 15))};
    end else if ($urandom_range(0, 1) == 0) begin
      c = {4'($urandom_range(0, OCT_MIN - 1)), 4'($urandom_range(0, NOTE_MAX))};
    end else begin
      c = {4'($urandom_range(OCT_MAX + 1, 15)), 4'($urandom_range(0, NOTE_MAX))};
    end
    return (c == NOTE_REST) ? 8'hFE : c;
  endfunction

  task automatic push_play(input logic [7:0] code, input logic [15:0] dur);
    note_reqs.push_back('{OP_PLAY, code, dur});
  endtask

  // Ticks carry random don't-care payload so every payload bit toggles.
  task automatic push_tick();
    note_reqs.push_back('{OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))});
  endtask

  // Hold the sender until everything queued has gone in and every
  // predicted result has come back out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (note_reqs.size() != 0 || in_valid_i || timer_cmds_due.size() != 0);
  endtask

  // Setup then access cycle; the register takes the value at the access edge.
  task automatic write_enable(input logic en);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(REG_ENABLED));
    pwdata  <= {31'($urandom()), en};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tone_enabled = en;
    if (!en) tone_playing = 1'b0;   // disable drops a running note silently
  endtask

  // Mostly well-formed notes/rests followed by their ticks, sprinkled with
  // busy requests, bad codes and idle ticks.
  task automatic random_phase(input int unsigned n_items);
    int unsigned made;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  code;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        code = ($urandom_range(0, 4) == 0) ? NOTE_REST : tone_code();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        push_play(code, 16'(len));
        for (int t = 0; t < len; t++) begin
          if ($urandom_range(0, 7) == 0) begin
            push_play(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            made++;
          end
          push_tick();
        end
        made += len + 1;
      end else if (kind < 9) begin
        push_play(bad_code(), 16'($urandom_range(0, 65535)));
        made++;
      end else begin
        push_tick();   // idle tick, ignored by the block
      end
    end
  endtask

  // Driver: offers queued items in bursts, and hands every accepted
  // transfer to the predictor.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    note_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        timer_cmds_due.push_back(sequence_step(opcode_i, note_code_i, duration_i));
      end
      // valid may only drop or change once the current item is taken
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (note_reqs.size() != 0) begin
          nxt = note_reqs.pop_front();
          opcode_i    <= nxt.op;
          note_code_i <= nxt.code;
          duration_i  <= nxt.dur;
          in_valid_i  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: scores each result transfer and shapes out_ready_i.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    timer_cmd_t due;
    timer_cmd_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      mode_left   <= 0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got = {status_o, timer_write_o, compare_value_o, clock_select_o, counter_clear_o};
        if (timer_cmds_due.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result: status %0d wr %0b cmp %0d sel %0d clr %0b",
                   $time, got.status, got.wr, got.cmp, got.sel, got.clr);
        end else begin
          due = timer_cmds_due.pop_front();
          if (got !== due) begin
            n_fail++;
            $display("%0t: result mismatch: expected status %0d wr %0b cmp %0d sel %0d clr %0b",
                     $time, due.status, due.wr, due.cmp, due.sel, due.clr);
            $display("%0t:                  actual   status %0d wr %0b cmp %0d sel %0d clr %0b",
                     $time, got.status, got.wr, got.cmp, got.sel, got.clr);
          end
        end
      end
      // one long hold-off while the sender keeps going, so the pipe backs up
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HOLDOFF_AT) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLDOFF_LEN;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(20, 80);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= $urandom_range(0, 1);
          end
          2: begin
            out_ready_i <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready_i <= !out_ready_i;
          end
        endcase
      end
    end
  end

  // Watchdog: any transfer on any port resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the block is disabled: requests refused, ticks ignored.
    push_play(8'h40, 16'd0);
    push_tick();
    wait_drained();

    write_enable(1'b1);
    // Lowest and highest tone, busy refusal, bad note/octave, a rest.
    push_play(8'h40, 16'd1);
    push_tick();
    push_play(8'h8B, 16'd2);
    push_play(8'h55, 16'hFFFF);   // busy: current note keeps running
    push_tick();
    push_tick();
    push_play(8'h4C, 16'd1);      // note above H
    push_play(8'h3A, 16'd1);      // octave too low
    push_play(8'h90, 16'd1);      // octave too high
    push_play(8'h0F, 16'd1);
    push_play(NOTE_REST, 16'd3);
    push_tick();
    push_tick();
    push_tick();
    push_tick();                  // idle tick
    push_play(8'h86, 16'hFFFF);   // long note, cut short by disabling below
    push_tick();
    push_tick();
    wait_drained();

    // Disable mid-note: the note vanishes with no finish report.
    write_enable(1'b0);
    push_tick();
    push_play(NOTE_REST, 16'd5);
    wait_drained();

    write_enable(1'b1);
    push_tick();                  // nothing playing any more
    push_play(8'h00, 16'd7);
    // Zero duration wraps: the count passes through all ones and the note
    // keeps running, so later requests are refused as busy.
    push_play(8'h47, 16'd0);
    for (int i = 0; i < 40; i++) push_tick();
    push_play(NOTE_REST, 16'd1);
    wait_drained();

    // Drop the wrapped note before the random traffic.
    write_enable(1'b0);
    write_enable(1'b1);

    random_phase(1200);
    wait_drained();

    write_enable(1'b0);
    random_phase(150);
    wait_drained();

    write_enable(1'b1);
    random_phase(450);
    wait_drained();

    // settle past the two-stage pipeline in case anything stray appears
    repeat (8) @(posedge clk_i);
    if (timer_cmds_due.size() != 0) begin
      n_fail++;
      $display("%0t: %0d expected results never arrived", $time, timer_cmds_due.size());
    end
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
